// File: rtl/blm_pkg.sv
// Shared constants, register codes and types of the battery level monitor.
package blm_pkg;

    // Samples summed into one block.
    localparam int BLOCK_SAMPLES = 10;

    localparam int SAMPLE_W   = 12;
    localparam int SUM_W      = 16;
    localparam int SCALE_W    = 16;
    localparam int CELL_W     = 4;
    localparam int VOLT_W     = 20;
    localparam int LEVEL_W    = 2;
    localparam int EVENT_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int CNT_W = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;

    // Block voltage = cell_count * sum * scale_milli / (3096 * BLOCK_SAMPLES).
    localparam int FULL_SCALE_DIV = 3096;
    localparam int DIVISOR        = FULL_SCALE_DIV * BLOCK_SAMPLES;
    localparam int REM_W          = $clog2(DIVISOR) + 1;
    localparam int PROD1_W        = CELL_W + SUM_W;
    localparam int NUM_W          = PROD1_W + SCALE_W;
    localparam int DIV_BITS       = 6;
    localparam int DIV_STEPS      = NUM_W / DIV_BITS;
    localparam int STEP_W         = $clog2(DIV_STEPS);

    localparam logic [VOLT_W-1:0] VOLT_MAX = '1;

    // Sum queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MILLI  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_MV  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_WEAK_MV      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_MODERATE_MV  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_ENTER_MV = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_EXIT_MV  = CFG_IDX_W'(6);

    // Register reset values.
    localparam logic [SCALE_W-1:0] RST_SCALE_MILLI  = SCALE_W'(14400);
    localparam logic [CELL_W-1:0]  RST_CELL_COUNT   = CELL_W'(1);
    localparam logic [VOLT_W-1:0]  RST_CRITICAL_MV  = VOLT_W'(7200);
    localparam logic [VOLT_W-1:0]  RST_WEAK_MV      = VOLT_W'(7600);
    localparam logic [VOLT_W-1:0]  RST_MODERATE_MV  = VOLT_W'(8000);
    localparam logic [VOLT_W-1:0]  RST_LOW_ENTER_MV = VOLT_W'(11500);
    localparam logic [VOLT_W-1:0]  RST_LOW_EXIT_MV  = VOLT_W'(12200);

    // Charge levels.
    localparam logic [LEVEL_W-1:0] LVL_CRITICAL  = LEVEL_W'(0);
    localparam logic [LEVEL_W-1:0] LVL_LOW       = LEVEL_W'(1);
    localparam logic [LEVEL_W-1:0] LVL_MODERATE  = LEVEL_W'(2);
    localparam logic [LEVEL_W-1:0] LVL_EXCELLENT = LEVEL_W'(3);

    // Event codes.
    localparam logic [EVENT_W-1:0] EVT_NONE       = EVENT_W'(0);
    localparam logic [EVENT_W-1:0] EVT_BECAME_LOW = EVENT_W'(1);
    localparam logic [EVENT_W-1:0] EVT_RECOVERED  = EVENT_W'(2);

    typedef struct packed {
        logic [SCALE_W-1:0] scale_milli;
        logic [CELL_W-1:0]  cell_count;
        logic [VOLT_W-1:0]  critical_mv;
        logic [VOLT_W-1:0]  weak_mv;
        logic [VOLT_W-1:0]  moderate_mv;
        logic [VOLT_W-1:0]  low_enter_mv;
        logic [VOLT_W-1:0]  low_exit_mv;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: rtl/blm_front.sv
// Front end: accepts samples and sums each block, pushing finished sums to the queue.
module blm_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [blm_pkg::SAMPLE_W-1:0] i_adc_sample,
    input  blm_pkg::t_q_status           i_q_status,
    output logic                         o_push,
    output logic [blm_pkg::SUM_W-1:0]    o_push_sum
);
    import blm_pkg::*;

    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_accept;
    logic             w_last;
    logic [SUM_W-1:0] w_sum_next;

    assign o_stall    = i_q_status.full;
    assign w_accept   = i_valid && !o_stall;
    assign w_last     = (r_count == CNT_W'(BLOCK_SAMPLES - 1));
    assign w_sum_next = r_sum + SUM_W'(i_adc_sample);
    assign o_push     = w_accept && w_last;
    assign o_push_sum = w_sum_next;

    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        if (w_accept) begin
            if (w_last) begin
                // restart the block
                n_sum   = '0;
                n_count = '0;
            end else begin
                n_sum   = w_sum_next;
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            r_sum   <= n_sum;
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/blm_queue.sv
// Short queue of block sums between the front and the back.
module blm_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [blm_pkg::SUM_W-1:0] i_push_sum,
    input  logic                      i_pop,
    output logic [blm_pkg::SUM_W-1:0] o_pop_sum,
    output blm_pkg::t_q_status        o_status
);
    import blm_pkg::*;

    logic [SUM_W-1:0]  r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_status.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;
    assign o_pop_sum      = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

endmodule

// File: rtl/blm_back.sv
// Back end: scales a block sum to millivolts, grades it and drives the result register.
module blm_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  blm_pkg::t_cfg                i_cfg,
    input  blm_pkg::t_q_status           i_q_status,
    input  logic [blm_pkg::SUM_W-1:0]    i_q_sum,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [blm_pkg::VOLT_W-1:0]   o_voltage_mv,
    output logic [blm_pkg::LEVEL_W-1:0]  o_charge_level,
    output logic                         o_low_flag,
    output logic [blm_pkg::EVENT_W-1:0]  o_event_code
);
    import blm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_CLS  = 4'b1000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [PROD1_W-1:0] r_prod1;
    logic [PROD1_W-1:0] n_prod1;
    logic [NUM_W-1:0]   r_num;
    logic [NUM_W-1:0]   n_num;
    logic [REM_W-1:0]   r_rem;
    logic [REM_W-1:0]   n_rem;
    logic [STEP_W-1:0]  r_step;
    logic [STEP_W-1:0]  n_step;
    logic               r_low;
    logic               n_low;
    logic               r_o_valid;
    logic               n_o_valid;
    logic [VOLT_W-1:0]  r_volt;
    logic [VOLT_W-1:0]  n_volt;
    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] n_level;
    logic [EVENT_W-1:0] r_event;
    logic [EVENT_W-1:0] n_event;

    logic [REM_W-1:0]   w_div_rem;
    logic [NUM_W-1:0]   w_div_num;
    logic [VOLT_W-1:0]  w_volt;
    logic [LEVEL_W-1:0] w_level;
    logic               w_out_free;

    // Several restoring-division steps per cycle; quotient bits shift into r_num.
    always_comb begin
        w_div_rem = r_rem;
        w_div_num = r_num;
        for (int k = 0; k < DIV_BITS; k++) begin
            w_div_rem = {w_div_rem[REM_W-2:0], w_div_num[NUM_W-1]};
            w_div_num = {w_div_num[NUM_W-2:0], 1'b0};
            if (w_div_rem >= REM_W'(DIVISOR)) begin
                w_div_rem    = w_div_rem - REM_W'(DIVISOR);
                w_div_num[0] = 1'b1;
            end
        end
    end

    // Saturate the quotient and grade it; first threshold that matches wins.
    always_comb begin
        w_volt = (|r_num[NUM_W-1:VOLT_W]) ? VOLT_MAX : r_num[VOLT_W-1:0];
        priority if (w_volt <= i_cfg.critical_mv) begin
            w_level = LVL_CRITICAL;
        end else if (w_volt <= i_cfg.weak_mv) begin
            w_level = LVL_LOW;
        end else if (w_volt <= i_cfg.moderate_mv) begin
            w_level = LVL_MODERATE;
        end else begin
            w_level = LVL_EXCELLENT;
        end
    end

    assign w_out_free = !r_o_valid || !i_stall;
    assign o_pop      = (r_state == S_IDLE) && !i_q_status.empty;

    always_comb begin
        n_state   = r_state;
        n_prod1   = r_prod1;
        n_num     = r_num;
        n_rem     = r_rem;
        n_step    = r_step;
        n_low     = r_low;
        n_o_valid = r_o_valid;
        n_volt    = r_volt;
        n_level   = r_level;
        n_event   = r_event;

        // drop the result once taken
        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    n_prod1 = PROD1_W'(i_cfg.cell_count) * PROD1_W'(i_q_sum);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_num   = NUM_W'(r_prod1) * NUM_W'(i_cfg.scale_milli);
                n_rem   = '0;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_num  = w_div_num;
                n_rem  = w_div_rem;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_CLS;
                end
            end
            S_CLS: begin
                // hold until the result register is free
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_volt    = w_volt;
                    n_level   = w_level;
                    n_event   = EVT_NONE;
                    if (r_low) begin
                        if (w_volt > i_cfg.low_exit_mv) begin
                            n_low   = 1'b0;
                            n_event = EVT_RECOVERED;
                        end
                    end else begin
                        if (w_volt < i_cfg.low_enter_mv) begin
                            n_low   = 1'b1;
                            n_event = EVT_BECAME_LOW;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_low     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_low     <= n_low;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod1 <= n_prod1;
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_volt  <= n_volt;
        r_level <= n_level;
        r_event <= n_event;
    end

    assign o_valid        = r_o_valid;
    assign o_voltage_mv   = r_volt;
    assign o_charge_level = r_level;
    assign o_low_flag     = r_low;
    assign o_event_code   = r_event;

endmodule

// File: rtl/battery_level_monitor_unit.sv
// Top level of the battery level monitor: configuration registers and the front/queue/back chain.
//
//   channel   direction  handshake                  payload
//   in        sink       i_in_valid / o_in_stall    i_adc_sample
//   out       source     o_out_valid / i_out_stall  o_voltage_mv, o_charge_level,
//                                                   o_low_flag, o_event_code
//   cfg       sink       i_cfg_we                   i_cfg_idx, i_cfg_data
//
// Samples are taken one per cycle while o_in_stall is low; every block of BLOCK_SAMPLES
// samples yields one result. The back end steps through S_IDLE, S_MUL, S_DIV and S_CLS:
// one multiply per cycle, then a 36-bit by 30960 division at 6 quotient bits per cycle.
// A two-entry sum queue lets the sampler run on while the back end works or the
// output is stalled; o_in_stall rises only when that queue is full.
// Reset (synchronous, active low) clears the sum, count, low flag and queue,
// and loads the register defaults.
module battery_level_monitor_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [blm_pkg::SAMPLE_W-1:0]   i_adc_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [blm_pkg::VOLT_W-1:0]     o_voltage_mv,
    output logic [blm_pkg::LEVEL_W-1:0]    o_charge_level,
    output logic                           o_low_flag,
    output logic [blm_pkg::EVENT_W-1:0]    o_event_code,
    input  logic                           i_cfg_we,
    input  logic [blm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [blm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import blm_pkg::*;

    t_cfg             r_cfg;
    t_cfg             n_cfg;
    t_q_status        w_q_status;
    logic             w_push;
    logic [SUM_W-1:0] w_push_sum;
    logic             w_pop;
    logic [SUM_W-1:0] w_pop_sum;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCALE_MILLI:  n_cfg.scale_milli  = i_cfg_data[SCALE_W-1:0];
                CFG_CELL_COUNT:   n_cfg.cell_count   = i_cfg_data[CELL_W-1:0];
                CFG_CRITICAL_MV:  n_cfg.critical_mv  = i_cfg_data[VOLT_W-1:0];
                CFG_WEAK_MV:      n_cfg.weak_mv      = i_cfg_data[VOLT_W-1:0];
                CFG_MODERATE_MV:  n_cfg.moderate_mv  = i_cfg_data[VOLT_W-1:0];
                CFG_LOW_ENTER_MV: n_cfg.low_enter_mv = i_cfg_data[VOLT_W-1:0];
                CFG_LOW_EXIT_MV:  n_cfg.low_exit_mv  = i_cfg_data[VOLT_W-1:0];
                default: begin
                    // ignore unmapped indexes
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_milli  <= RST_SCALE_MILLI;
            r_cfg.cell_count   <= RST_CELL_COUNT;
            r_cfg.critical_mv  <= RST_CRITICAL_MV;
            r_cfg.weak_mv      <= RST_WEAK_MV;
            r_cfg.moderate_mv  <= RST_MODERATE_MV;
            r_cfg.low_enter_mv <= RST_LOW_ENTER_MV;
            r_cfg.low_exit_mv  <= RST_LOW_EXIT_MV;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    blm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_adc_sample (i_adc_sample),
        .i_q_status   (w_q_status),
        .o_push       (w_push),
        .o_push_sum   (w_push_sum)
    );

    blm_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_sum (w_push_sum),
        .i_pop      (w_pop),
        .o_pop_sum  (w_pop_sum),
        .o_status   (w_q_status)
    );

    blm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_status     (w_q_status),
        .i_q_sum        (w_pop_sum),
        .o_pop          (w_pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_voltage_mv   (o_voltage_mv),
        .o_charge_level (o_charge_level),
        .o_low_flag     (o_low_flag),
        .o_event_code   (o_event_code)
    );

endmodule
